[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the interpolator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/brip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brip_pkg
// Shared types and constants of the bilinear record interpolator.
// ----------------------------------------------------------------------------
package brip_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int FB          = 8;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CHANNELS    = 6;
    localparam int CH_W        = 16;
    localparam int GRID_W      = 16;
    localparam int RW_W        = 9;
    localparam int CMD_DEPTH   = 4;
    localparam int RES_DEPTH   = 4;

    localparam int CH_X       = 0;
    localparam int CH_Y       = 1;
    localparam int CH_Z       = 2;
    localparam int CH_HEADING = 3;
    localparam int CH_PITCH   = 4;
    localparam int CH_ROLL    = 5;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_RANGE
    } t_op;

    typedef enum logic {
        PH_LEFT,
        PH_RIGHT
    } t_phase;

    typedef logic [CHANNELS-1:0][CH_W-1:0] t_rec;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [FB-1:0]     xf;
        logic [FB-1:0]     yf;
        t_rec              rec;
    } t_cmd;

    typedef struct packed {
        t_rec val;
        logic oor;
    } t_res;

endpackage

[sv/brip_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brip_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module brip_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brip_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output brip_pkg::t_cmd o_cmd
);
    import brip_pkg::*;

    localparam int AW = $clog2(CMD_DEPTH);

    t_cmd            r_mem [CMD_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;
    logic            wr_en;
    logic            rd_en;

    assign o_full  = (r_count == (AW+1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

[sv/brip_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brip_front
// Holds the row width, computes corner addresses and classifies each item.
// ----------------------------------------------------------------------------
module brip_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [brip_pkg::RW_W-1:0]  i_cfg_row_width,
    input  logic                       i_accept,
    input  logic                       i_kind,
    input  logic [7:0]                 i_entry_index,
    input  brip_pkg::t_rec             i_rec,
    input  logic [brip_pkg::GRID_W-1:0] i_grid_x,
    input  logic [brip_pkg::GRID_W-1:0] i_grid_y,
    output logic                       o_push,
    output brip_pkg::t_cmd             o_cmd
);
    import brip_pkg::*;

    localparam int WHOLE_W = GRID_W - FB;
    localparam int IDX_W   = WHOLE_W + RW_W + 2;

    logic [RW_W-1:0]    r_row_width;
    logic [WHOLE_W-1:0] xw;
    logic [WHOLE_W-1:0] yw;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
    logic [IDX_W-1:0]   idx_last;
    logic               in_table;
    logic               load_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RW_W'(1);
        end else if (i_cfg_valid) begin
            r_row_width <= i_cfg_row_width;
        end
    end

    assign xw       = i_grid_x[GRID_W-1:FB];
    assign yw       = i_grid_y[GRID_W-1:FB];
    assign idx_a    = IDX_W'(yw) * IDX_W'(r_row_width) + IDX_W'(xw);
    assign idx_b    = idx_a + IDX_W'(r_row_width);
    assign idx_last = idx_b + IDX_W'(1);
    assign in_table = (idx_last < IDX_W'(TABLE_DEPTH));
    assign load_ok  = (32'(i_entry_index) < TABLE_DEPTH);

    // Loads that point past the table are dropped here and never queued.
    assign o_push = i_accept && ((i_kind != KIND_LOAD) || load_ok);

    always_comb begin
        o_cmd.rec = i_rec;
        o_cmd.xf  = i_grid_x[FB-1:0];
        o_cmd.yf  = i_grid_y[FB-1:0];
        if (i_kind == KIND_LOAD) begin
            o_cmd.op     = OP_LOAD;
            o_cmd.addr_a = ADDR_W'(i_entry_index);
            o_cmd.addr_b = ADDR_W'(i_entry_index);
        end else begin
            o_cmd.op     = in_table ? OP_QUERY : OP_RANGE;
            o_cmd.addr_a = idx_a[ADDR_W-1:0];
            o_cmd.addr_b = idx_b[ADDR_W-1:0];
        end
    end

endmodule

[sv/brip_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brip_back
// Record table, two-column fetch sequencer, interpolation pipe, result queue.
// ----------------------------------------------------------------------------
module brip_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  brip_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output brip_pkg::t_res o_res
);
    import brip_pkg::*;

    localparam int RAW = $clog2(RES_DEPTH);

    function automatic logic [CH_W-1:0] lerp(
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b,
        input logic [FB-1:0]   f
    );
        logic signed [CH_W:0]      d;
        logic signed [CH_W+FB+1:0] p;
        d = $signed({b[CH_W-1], b}) - $signed({a[CH_W-1], a});
        p = d * $signed({1'b0, f});
        return a + p[FB +: CH_W];
    endfunction

    // Table memory: one write port, two registered read ports.
    t_rec              r_mem [TABLE_DEPTH];
    t_rec              r_rd_a;
    t_rec              r_rd_b;

    t_phase            r_phase;
    t_phase            n_phase;

    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              mem_we;
    logic              issue;
    logic              issue_last;
    logic              issue_oor;
    logic              reserve;
    logic              space;

    logic              r_s1_vld;
    logic              r_s1_last;
    logic              r_s1_oor;
    logic [FB-1:0]     r_s1_xf;
    logic [FB-1:0]     r_s1_yf;
    logic              r_s2_vld;
    logic              r_s2_last;
    logic              r_s2_oor;
    logic [FB-1:0]     r_s2_xf;
    t_rec              r_s2_y;
    t_rec              r_left;
    t_rec              ylerp;
    t_res              res_in;

    t_res              r_res_mem [RES_DEPTH];
    logic [RAW-1:0]    r_res_wr;
    logic [RAW-1:0]    r_res_rd;
    logic [RAW:0]      r_res_cnt;
    logic [RAW:0]      r_inflight;
    logic              res_wr;
    logic              res_rd;

    // A result slot is reserved when a query starts, so the pipe never stalls.
    assign space = ((RAW+2)'(r_res_cnt) + (RAW+2)'(r_inflight)) < (RAW+2)'(RES_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEFT;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_LEFT: begin
                if (i_cmd_valid && (i_cmd.op == OP_QUERY) && space) begin
                    n_phase = PH_RIGHT;
                end
            end
            PH_RIGHT: begin
                n_phase = PH_LEFT;
            end
            default: begin
                n_phase = PH_LEFT;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;
        issue      = 1'b0;
        issue_last = 1'b0;
        issue_oor  = 1'b0;
        reserve    = 1'b0;
        rd_addr_a  = i_cmd.addr_a;
        rd_addr_b  = i_cmd.addr_b;
        case (r_phase)
            PH_LEFT: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_LOAD: begin
                            mem_we    = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        OP_RANGE: begin
                            if (space) begin
                                issue      = 1'b1;
                                issue_last = 1'b1;
                                issue_oor  = 1'b1;
                                reserve    = 1'b1;
                                o_cmd_pop  = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (space) begin
                                issue   = 1'b1;
                                reserve = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            PH_RIGHT: begin
                rd_addr_a  = i_cmd.addr_a + ADDR_W'(1);
                rd_addr_b  = i_cmd.addr_b + ADDR_W'(1);
                issue      = 1'b1;
                issue_last = 1'b1;
                o_cmd_pop  = 1'b1;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.addr_a] <= i_cmd.rec;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Lerp along y on the fetched column, one lane per channel.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            ylerp[c] = lerp(r_rd_a[c], r_rd_b[c], r_s1_yf);
        end
    end

    // Lerp along x between the held left column and the current right column.
    always_comb begin
        res_in.oor = r_s2_oor;
        for (int c = 0; c < CHANNELS; c++) begin
            res_in.val[c] = r_s2_oor ? '0 : lerp(r_left[c], r_s2_y[c], r_s2_xf);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= issue_last;
        r_s1_oor  <= issue_oor;
        r_s1_xf   <= i_cmd.xf;
        r_s1_yf   <= i_cmd.yf;
        r_s2_last <= r_s1_last;
        r_s2_oor  <= r_s1_oor;
        r_s2_xf   <= r_s1_xf;
        r_s2_y    <= ylerp;
        if (r_s2_vld && !r_s2_last) begin
            r_left <= r_s2_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    assign res_wr  = r_s2_vld && r_s2_last;
    assign res_rd  = i_pop && !o_empty;
    assign o_empty = (r_res_cnt == '0);
    assign o_res   = r_res_mem[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_res_mem[r_res_wr] <= res_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr   <= '0;
            r_res_rd   <= '0;
            r_res_cnt  <= '0;
            r_inflight <= '0;
        end else begin
            if (res_wr) begin
                r_res_wr <= r_res_wr + RAW'(1);
            end
            if (res_rd) begin
                r_res_rd <= r_res_rd + RAW'(1);
            end
            r_res_cnt  <= r_res_cnt + (RAW+1)'(res_wr) - (RAW+1)'(res_rd);
            r_inflight <= r_inflight + (RAW+1)'(reserve) - (RAW+1)'(res_wr);
        end
    end

endmodule

[sv/bilinear_record_interpolator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_record_interpolator_unit
// Table of six-channel records with a bilinear query path.
// ----------------------------------------------------------------------------
// Usage: items enter through a queue-style port (push, full). A beat with
// i_kind low writes one record at i_entry_index and gives no result. A beat
// with i_kind high is a query: the whole parts of i_grid_x and i_grid_y pick
// four neighboring records, which are blended with the 8-bit fractions, first
// along y and then along x. A query whose far corner lies past the table
// gives zeros with o_out_of_range set. Results leave through a second queue
// port (empty, pop) in the order the queries arrived.
// The row width is written through the i_cfg_valid / o_cfg_ready channel and
// resets to one record per row; the user must write it only while the block
// is idle, as the block itself does not enforce this. A query inside the
// table fetches its left, then its right column, since the dual-port table
// memory delivers two corner records per cycle, and is blended along y, then
// x; a load is one table write. Later commands may overlap earlier queries.
// A four-deep command queue separates acceptance from execution, and a
// four-entry result queue holds finished beats while the receiver does not
// pop. A stalled receiver fills the result queue, then the command queue,
// then raises full. Reset (synchronous, active low) empties both queues;
// table contents are kept and must be written before they are read.
// ----------------------------------------------------------------------------
module bilinear_record_interpolator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_row_width,
    input  logic               push,
    output logic               full,
    input  logic               i_kind,
    input  logic [7:0]         i_entry_index,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic signed [15:0] i_heading_val,
    input  logic signed [15:0] i_pitch_val,
    input  logic signed [15:0] i_roll_val,
    input  logic [15:0]        i_grid_x,
    input  logic [15:0]        i_grid_y,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic signed [15:0] o_out_heading,
    output logic signed [15:0] o_out_pitch,
    output logic signed [15:0] o_out_roll,
    output logic               o_out_of_range
);
    import brip_pkg::*;

    t_rec in_rec;
    t_cmd front_cmd;
    t_cmd head_cmd;
    t_res res;
    logic front_push;
    logic head_valid;
    logic head_pop;
    logic accept;

    // An input beat is taken whenever the command queue has room.
    assign accept = push && !full;

    always_comb begin
        in_rec             = '0;
        in_rec[CH_X]       = i_pos_x;
        in_rec[CH_Y]       = i_pos_y;
        in_rec[CH_Z]       = i_pos_z;
        in_rec[CH_HEADING] = i_heading_val;
        in_rec[CH_PITCH]   = i_pitch_val;
        in_rec[CH_ROLL]    = i_roll_val;
    end

    brip_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_row_width (i_cfg_row_width),
        .i_accept        (accept),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_rec           (in_rec),
        .i_grid_x        (i_grid_x),
        .i_grid_y        (i_grid_y),
        .o_push          (front_push),
        .o_cmd           (front_cmd)
    );

    brip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    brip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (head_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_out_x        = res.val[CH_X];
    assign o_out_y        = res.val[CH_Y];
    assign o_out_z        = res.val[CH_Z];
    assign o_out_heading  = res.val[CH_HEADING];
    assign o_out_pitch    = res.val[CH_PITCH];
    assign o_out_roll     = res.val[CH_ROLL];
    assign o_out_of_range = res.oor;

endmodule

[sv/brip_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brip_checker
// Port-level checks on the interpolator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brip_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [8:0]         i_cfg_row_width,
    input logic               push,
    input logic               full,
    input logic               i_kind,
    input logic [7:0]         i_entry_index,
    input logic signed [15:0] i_pos_x,
    input logic signed [15:0] i_pos_y,
    input logic signed [15:0] i_pos_z,
    input logic signed [15:0] i_heading_val,
    input logic signed [15:0] i_pitch_val,
    input logic signed [15:0] i_roll_val,
    input logic [15:0]        i_grid_x,
    input logic [15:0]        i_grid_y,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] o_out_x,
    input logic signed [15:0] o_out_y,
    input logic signed [15:0] o_out_z,
    input logic signed [15:0] o_out_heading,
    input logic signed [15:0] o_out_pitch,
    input logic signed [15:0] o_out_roll,
    input logic               o_out_of_range
);

    // After reset both queues are empty.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (empty && !full), "queues not empty after reset")

    // A waiting result beat keeps its x and roll values and its range flag while the receiver does not pop.
    `ASSERT_CLK(a_result_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out_x) && $stable(o_out_roll) && $stable(o_out_of_range)), "stalled result changed")

    // An out-of-range query carries zero values on every channel.
    `ASSERT_CLK(a_range_zero, i_clk, i_rst_n, (!empty && o_out_of_range) |-> (o_out_x == 16'sd0 && o_out_y == 16'sd0 && o_out_z == 16'sd0 && o_out_heading == 16'sd0 && o_out_pitch == 16'sd0 && o_out_roll == 16'sd0), "out-of-range result not zero")

    // The command queue can only fill up through a beat pushed in the cycle before.
    `ASSERT_CLK(a_full_after_push, i_clk, i_rst_n, $rose(full) |-> $past(push), "full rose without a push")

endmodule

bind bilinear_record_interpolator_unit brip_checker u_brip_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear record interpolator.
// ----------------------------------------------------------------------------
// Load and query beats go in through the push/full port in bursts with random
// gaps, while the result port is popped on a changing stall pattern. A local
// copy of the record table and of the row width predicts every query result,
// and each popped beat is compared channel by channel with the oldest
// prediction. The row width is swept through the normal, degenerate and
// oversized settings, and is only rewritten once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb;

    import brip_pkg::*;

    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT = 600_000;
    // Quiet time before a register write and at the end. Loads give no result
    // beat, so the block may still be busy once the last result has arrived.
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_TRICKLE,
        SINK_BLOCKY
    } t_sink_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [8:0]         i_cfg_row_width;
    logic               push;
    logic               full;
    logic               i_kind;
    logic [7:0]         i_entry_index;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic signed [15:0] i_pos_z;
    logic signed [15:0] i_heading_val;
    logic signed [15:0] i_pitch_val;
    logic signed [15:0] i_roll_val;
    logic [15:0]        i_grid_x;
    logic [15:0]        i_grid_y;
    logic               empty;
    logic               pop;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic signed [15:0] o_out_z;
    logic signed [15:0] o_out_heading;
    logic signed [15:0] o_out_pitch;
    logic signed [15:0] o_out_roll;
    logic               o_out_of_range;

    // Local copy of the block state, updated as each beat is accepted.
    t_rec       record_copy [TABLE_DEPTH];
    bit         record_valid [TABLE_DEPTH];
    logic [8:0] row_width_now;

    // Predicted query results, oldest first.
    t_res pending_results [$];

    int         mismatches;
    int         burst_left;
    int         cycle_count;
    int unsigned stall_tick;
    t_sink_mode sink_mode;
    t_res       front_result;
    t_rec       seen_val;
    string      chan_name [CHANNELS] = '{"x", "y", "z", "heading", "pitch", "roll"};

    assign seen_val = {o_out_roll, o_out_pitch, o_out_heading, o_out_z, o_out_y, o_out_x};

    bilinear_record_interpolator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_row_width (i_cfg_row_width),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_heading_val   (i_heading_val),
        .i_pitch_val     (i_pitch_val),
        .i_roll_val      (i_roll_val),
        .i_grid_x        (i_grid_x),
        .i_grid_y        (i_grid_y),
        .empty           (empty),
        .pop             (pop),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_heading   (o_out_heading),
        .o_out_pitch     (o_out_pitch),
        .o_out_roll      (o_out_roll),
        .o_out_of_range  (o_out_of_range)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every cycle counts toward the limit; hitting it means the block hung.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One linear step from a toward b by f / 2^FB. The arithmetic shift of the
    // signed product rounds toward minus infinity, as the block truncates.
    function automatic int lerp_step(int a, int b, int f);
        return a + (((b - a) * f) >>> FB);
    endfunction

    // Blend the four corner records picked by a grid coordinate pair: first
    // along y in the left and right columns, then along x between the two.
    function automatic t_res blend_query(logic [15:0] gx, logic [15:0] gy);
        t_res r;
        int   base;
        int   lower;
        int   left;
        int   right;
        int   xf;
        int   yf;
        r     = '0;
        xf    = int'(gx[FB-1:0]);
        yf    = int'(gy[FB-1:0]);
        base  = int'(gy >> FB) * int'(row_width_now) + int'(gx >> FB);
        lower = base + int'(row_width_now);
        // The far corner past the table gives zeros and the range flag.
        if (lower + 1 >= TABLE_DEPTH) begin
            r.oor = 1'b1;
            return r;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            left  = lerp_step($signed(record_copy[base][c]),
                              $signed(record_copy[lower][c]), yf);
            right = lerp_step($signed(record_copy[base + 1][c]),
                              $signed(record_copy[lower + 1][c]), yf);
            r.val[c] = 16'(lerp_step(left, right, xf));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking and result-side stalls
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // A result beat is taken at an edge where pop is high and empty is low;
    // both are read before the edge updates them, as the block sees them.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no query pending", 0, 0);
            end else begin
                front_result = pending_results.pop_front();
                for (int c = 0; c < CHANNELS; c++)
                    if (seen_val[c] !== front_result.val[c])
                        report_mismatch(chan_name[c], $signed(seen_val[c]),
                                        $signed(front_result.val[c]));
                if (o_out_of_range !== front_result.oor)
                    report_mismatch("out_of_range", o_out_of_range, front_result.oor);
            end
        end

        // The receiver changes its habit at random: popping at once, popping at
        // random, a slow trickle, or long on and off stretches.
        stall_tick++;
        if (stall_tick % 128 == 0)
            sink_mode = t_sink_mode'($urandom_range(0, 3));
        case (sink_mode)
            SINK_ALWAYS:  pop <= 1'b1;
            SINK_RANDOM:  pop <= ($urandom_range(0, 3) != 0);
            SINK_TRICKLE: pop <= ((stall_tick % 16) < 3);
            default:      pop <= stall_tick[5];
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [15:0] random_channel();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_rec random_record();
        t_rec r;
        for (int c = 0; c < CHANNELS; c++)
            r[c] = random_channel();
        return r;
    endfunction

    function automatic logic [7:0] random_fraction();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Send one beat. The sender works in bursts: when a burst is used up it
    // may drop push before the next one begins. Push stays high between beats
    // of one burst, so it is never lowered and raised at the same edge.
    task automatic send_beat(input logic kind, input logic [7:0] idx, input t_rec rec,
                             input logic [15:0] gx, input logic [15:0] gy);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push          <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_pos_x       <= rec[CH_X];
        i_pos_y       <= rec[CH_Y];
        i_pos_z       <= rec[CH_Z];
        i_heading_val <= rec[CH_HEADING];
        i_pitch_val   <= rec[CH_PITCH];
        i_roll_val    <= rec[CH_ROLL];
        i_grid_x      <= gx;
        i_grid_y      <= gy;
        do @(posedge i_clk); while (full);
        if (kind == KIND_LOAD) begin
            record_copy[idx]  = rec;
            record_valid[idx] = 1'b1;
        end else begin
            pending_results.push_back(blend_query(gx, gy));
        end
    endtask

    task automatic load_beat(input logic [7:0] idx, input t_rec rec);
        send_beat(KIND_LOAD, idx, rec, 16'($urandom), 16'($urandom));
    endtask

    // Send a query. Table contents are undefined after reset, so any corner of an
    // in-table query that was never written is first loaded with random content.
    task automatic query_beat(input logic [15:0] gx, input logic [15:0] gy);
        int base;
        int corner [4];
        base   = int'(gy >> FB) * int'(row_width_now) + int'(gx >> FB);
        corner = '{base, base + 1, base + int'(row_width_now),
                   base + int'(row_width_now) + 1};
        if (corner[3] < TABLE_DEPTH)
            foreach (corner[k])
                if (!record_valid[corner[k]])
                    load_beat(8'(corner[k]), random_record());
        send_beat(KIND_QUERY, 8'($urandom), random_record(), gx, gy);
    endtask

    // Most queries land inside the table for the current row width; the rest
    // take any coordinate, which mostly runs off the end.
    function automatic void pick_grid(output logic [15:0] gx, output logic [15:0] gy);
        int w;
        int xw;
        int yw;
        int ymax;
        w = int'(row_width_now);
        if (w >= TABLE_DEPTH - 1 || $urandom_range(0, 3) == 0) begin
            gx = 16'($urandom);
            gy = 16'($urandom);
            return;
        end
        if (w == 0) begin
            yw = $urandom_range(0, 255);
            xw = $urandom_range(0, TABLE_DEPTH - 2);
        end else begin
            ymax = (TABLE_DEPTH - 2 - w) / w;
            yw   = $urandom_range(0, ymax);
            xw   = $urandom_range(0, TABLE_DEPTH - 2 - w - yw * w);
        end
        gx = {8'(xw), random_fraction()};
        gy = {8'(yw), random_fraction()};
    endfunction

    task automatic random_beats(input int count);
        logic [15:0] gx;
        logic [15:0] gy;
        repeat (count) begin
            if ($urandom_range(0, 99) < 35) begin
                load_beat(8'($urandom), random_record());
            end else begin
                pick_grid(gx, gy);
                query_beat(gx, gy);
            end
        end
    endtask

    // Let every pending result drain, then give the block time to finish any
    // loads still in its command queue.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_row_width(input logic [8:0] w);
        wait_idle();
        i_cfg_row_width <= w;
        i_cfg_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        row_width_now  = w;
        burst_left     = 0;
    endtask

    // One phase at a given row width: for widths 1 to 127, a query on the right edge
    // of the first row, whose +1 neighbor wraps to the next row, then random beats.
    task automatic run_width(input logic [8:0] w, input int count);
        set_row_width(w);
        if (w >= 1 && w <= 127)
            query_beat({8'(w - 1), 8'h80}, 16'h0040);
        random_beats(count);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // At the reset row width of one: records with extreme channels, queries
    // at zero and full fractions, and queries on both sides of the table end.
    task automatic test_directed_extremes();
        load_beat(8'd0, {CHANNELS{16'h7FFF}});
        load_beat(8'd1, {CHANNELS{16'h8000}});
        load_beat(8'd2, {16'h0100, 16'hCFC7, 16'h3039, 16'h0001, 16'hFFFF, 16'h0000});
        load_beat(8'd3, {CHANNELS{16'hFFFF}});
        query_beat(16'h0000, 16'h0000);
        query_beat(16'h00FF, 16'h0000);
        query_beat(16'h0000, 16'h00FF);
        query_beat(16'h00FF, 16'h00FF);
        query_beat(16'h0180, 16'h0080);
        query_beat(16'h0080, 16'h0100);
        // Far corner lands on the last entry: still inside.
        query_beat(16'h0000, 16'hFD00);
        // Far corner one past the last entry, two past it, and far beyond it.
        query_beat(16'hFE00, 16'h0000);
        query_beat(16'h0000, 16'hFF00);
        query_beat(16'hFFFF, 16'hFFFF);
    endtask

    // Row widths of zero and of 254 and more, up to 511, taken as written.
    task automatic test_degenerate_widths();
        run_width(9'd0, 120);
        run_width(9'd255, 60);
        run_width(9'd256, 60);
        run_width(9'd511, 40);
        run_width(9'd254, 60);
    endtask

    task automatic test_typical_widths();
        run_width(9'd7, 150);
        run_width(9'd16, 150);
        run_width(9'd100, 100);
        run_width(9'($urandom_range(2, 64)), 250);
    endtask

    task automatic test_reset_width_again();
        run_width(9'd1, 150);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_row_width <= '0;
        push            <= 1'b0;
        pop             <= 1'b0;
        i_kind          <= KIND_LOAD;
        i_entry_index   <= '0;
        i_pos_x         <= '0;
        i_pos_y         <= '0;
        i_pos_z         <= '0;
        i_heading_val   <= '0;
        i_pitch_val     <= '0;
        i_roll_val      <= '0;
        i_grid_x        <= '0;
        i_grid_y        <= '0;
        row_width_now    = 9'd1;
        mismatches       = 0;
        burst_left       = 0;
        cycle_count      = 0;
        stall_tick       = 0;
        sink_mode        = SINK_ALWAYS;
        foreach (record_valid[k])
            record_valid[k] = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_degenerate_widths();
        test_typical_widths();
        test_reset_width_again();

        wait_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/brip_pkg.sv
sv/brip_queue.sv
sv/brip_front.sv
sv/brip_back.sv
sv/bilinear_record_interpolator_unit.sv
sv/brip_checker.sv
verif/tb.sv
